@@ sv/first_fit_block_allocator_defines.svh @@
// assertion macros for the first-fit block allocator checker
// no dependencies; included by the checker file
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ffa_pkg.sv @@
// shared types and constants of the first-fit block allocator
// no dependencies; imported by all modules of the block
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    // field widths that do not vary
    localparam int STATUS_W = 3;
    localparam int ARENA_W  = 25;

    localparam logic [ARENA_W-1:0] ARENA_RESET = 25'd16777216;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL     = 3'd4;

    // table port strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

@@ sv/ffa_table.sv @@
// block table memory: one write port, one read port, registered read data
// depends on ffa_pkg for the port strobe struct
`timescale 1ns / 1ps
`default_nettype none

module ffa_table #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6,
    parameter int DATA_W = 49
) (
    input  wire                    i_clk,
    input  ffa_pkg::t_mem_ctl      i_ctl,
    input  wire  [IDX_W-1:0]       i_rd_addr,
    input  wire  [IDX_W-1:0]       i_wr_addr,
    input  wire  [DATA_W-1:0]      i_wr_data,
    output logic [DATA_W-1:0]      o_rd_data
);
    import ffa_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data registered while the read strobe is high
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/ffa_ctrl.sv @@
// request sequencer: latches a request, scans the block table, writes back
// depends on ffa_pkg; drives the ffa_table ports
`timescale 1ns / 1ps
`default_nettype none

module ffa_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32,
    parameter int ADDR_BITS    = 24,
    parameter int IDX_W        = 6,
    parameter int ENT_W        = 49
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // request
    input  wire                           i_start,
    output logic                          o_busy,
    input  wire                           i_kind,
    input  wire  [ADDR_BITS-1:0]          i_size,
    input  wire  [ADDR_BITS-1:0]          i_address,
    // result
    output logic                          o_valid,
    output logic [ffa_pkg::STATUS_W-1:0]  o_status,
    output logic [ADDR_BITS-1:0]          o_address_out,
    // arena register write
    input  wire                           i_cfg_valid,
    input  wire  [ffa_pkg::ARENA_W-1:0]   i_cfg_data,
    // table port
    output ffa_pkg::t_mem_ctl             o_mem_ctl,
    output logic [IDX_W-1:0]              o_rd_addr,
    output logic [IDX_W-1:0]              o_wr_addr,
    output logic [ENT_W-1:0]              o_wr_data,
    input  wire  [ENT_W-1:0]              i_rd_data
);
    import ffa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ((ADDR_BITS > ARENA_W) ? ADDR_BITS : ARENA_W) + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]           r_state, n_state;
    logic                 r_kind, n_kind;
    logic [ADDR_BITS-1:0] r_size, n_size;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [ARENA_W-1:0]   r_brk, n_brk;
    logic [ARENA_W-1:0]   r_arena, n_arena;
    logic [SUM_W-1:0]     r_app_daddr, n_app_daddr;
    logic [SUM_W-1:0]     r_app_end, n_app_end;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_vld, n_vld;
    logic [IDX_W-1:0]     r_chk_idx, n_chk_idx;
    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [ADDR_BITS-1:0] r_out_addr, n_out_addr;

    // fields of the entry returned by the table
    logic                 ent_used;
    logic [ADDR_BITS-1:0] ent_daddr;
    logic [ADDR_BITS-1:0] ent_len;
    logic                 alloc_fit;
    logic                 free_match;
    logic                 exhausted;
    logic                 app_fail;

    assign ent_used  = i_rd_data[2*ADDR_BITS];
    assign ent_daddr = i_rd_data[2*ADDR_BITS-1:ADDR_BITS];
    assign ent_len   = i_rd_data[ADDR_BITS-1:0];

    assign alloc_fit  = !ent_used && (ent_len >= r_size);
    assign free_match = (ent_daddr == r_addr);
    assign exhausted  = !r_vld && (r_rd_idx >= r_count);

    // append fails on a full table, on passing the arena, or past the address space
    assign app_fail = (r_count == CNT_W'(MAX_BLOCKS))
                   || (r_app_end > SUM_W'(r_arena))
                   || (|r_app_daddr[SUM_W-1:ADDR_BITS]);

    // sequencer next state and table accesses
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_size      = r_size;
        n_addr      = r_addr;
        n_count     = r_count;
        n_brk       = r_brk;
        n_arena     = r_arena;
        n_app_daddr = r_app_daddr;
        n_app_end   = r_app_end;
        n_rd_idx    = r_rd_idx;
        n_vld       = r_vld;
        n_chk_idx   = r_chk_idx;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_out_addr  = r_out_addr;
        o_mem_ctl   = '0;
        o_rd_addr   = r_rd_idx[IDX_W-1:0];
        o_wr_addr   = r_chk_idx;
        o_wr_data   = i_rd_data;

        if (i_cfg_valid) begin
            n_arena = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_kind == KIND_FREE && i_address == '0) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_NULL;
                        n_out_addr  = '0;
                    end else begin
                        n_kind      = i_kind;
                        n_size      = i_size;
                        n_addr      = i_address;
                        n_app_daddr = SUM_W'(r_brk) + SUM_W'(HEADER_BYTES);
                        n_state     = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_app_end = r_app_daddr + SUM_W'(r_size);
                n_rd_idx  = '0;
                n_vld     = 1'b0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (r_vld && r_kind == KIND_ALLOC && alloc_fit) begin
                    // reuse the first free block that covers the request
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_data       = {1'b1, ent_daddr, ent_len};
                    n_out_valid     = 1'b1;
                    n_status        = ST_OK;
                    n_out_addr      = ent_daddr;
                    n_state         = S_IDLE;
                end else if (r_vld && r_kind == KIND_FREE && free_match) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = '0;
                    if (!ent_used) begin
                        n_status = ST_DOUBLE;
                    end else begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_wr_data       = {1'b0, ent_daddr, ent_len};
                        n_status        = ST_OK;
                    end
                    n_state = S_IDLE;
                end else if (exhausted) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_kind == KIND_FREE) begin
                        n_status   = ST_NOTFOUND;
                        n_out_addr = '0;
                    end else if (app_fail) begin
                        n_status   = ST_OOM;
                        n_out_addr = '0;
                    end else begin
                        // append a new block at the break
                        o_mem_ctl.wr_en = 1'b1;
                        o_wr_addr       = r_count[IDX_W-1:0];
                        o_wr_data       = {1'b1, r_app_daddr[ADDR_BITS-1:0], r_size};
                        n_count         = r_count + CNT_W'(1);
                        n_brk           = r_app_end[ARENA_W-1:0];
                        n_status        = ST_OK;
                        n_out_addr      = r_app_daddr[ADDR_BITS-1:0];
                    end
                end else if (r_rd_idx < r_count) begin
                    // next read in flight while the previous entry is checked
                    o_mem_ctl.rd_en = 1'b1;
                    n_chk_idx       = r_rd_idx[IDX_W-1:0];
                    n_rd_idx        = r_rd_idx + CNT_W'(1);
                    n_vld           = 1'b1;
                end else begin
                    n_vld = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_brk       <= '0;
            r_arena     <= ARENA_RESET;
            r_vld       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_brk       <= n_brk;
            r_arena     <= n_arena;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_size      <= n_size;
        r_addr      <= n_addr;
        r_app_daddr <= n_app_daddr;
        r_app_end   <= n_app_end;
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_status    <= n_status;
        r_out_addr  <= n_out_addr;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_address_out = r_out_addr;

endmodule

`default_nettype wire

@@ sv/first_fit_block_allocator.sv @@
// top level of the first-fit block allocator: sequencer plus block table
// depends on ffa_pkg, ffa_ctrl and ffa_table
//
//  channel   handshake                     beat
//  request   start, busy                   i_kind, i_size, i_address
//  result    o_valid (one-cycle strobe)    o_status, o_address_out
//  config    i_cfg_valid, o_cfg_ready      i_cfg_data (arena bytes)
//
// a request scans the table entries below the block count in order until a
// match, then gives its result strobe; the scan reads one table entry per
// cycle through the single read port of the block table
// a null free gives its result in the cycle after accept
// synchronous active-low reset; the table needs no clearing pass, entries
// at or past the block count are never read
// the result strobe cannot be stalled; a new request may be accepted in it
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32,
    parameter int ADDR_BITS    = 24
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           i_kind,
    input  wire  [ADDR_BITS-1:0]          i_size,
    input  wire  [ADDR_BITS-1:0]          i_address,
    output logic                          o_valid,
    output logic [ffa_pkg::STATUS_W-1:0]  o_status,
    output logic [ADDR_BITS-1:0]          o_address_out,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [ffa_pkg::ARENA_W-1:0]   i_cfg_data
);
    import ffa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ENT_W = 2 * ADDR_BITS + 1;

    t_mem_ctl         mem_ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [ENT_W-1:0] rd_data;

    // arena register is always writable
    assign o_cfg_ready = 1'b1;

    ffa_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS),
        .IDX_W        (IDX_W),
        .ENT_W        (ENT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_kind        (i_kind),
        .i_size        (i_size),
        .i_address     (i_address),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_address_out (o_address_out),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_mem_ctl     (mem_ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_rd_data     (rd_data)
    );

    ffa_table #(
        .DEPTH  (MAX_BLOCKS),
        .IDX_W  (IDX_W),
        .DATA_W (ENT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

@@ sv/ffa_checker.sv @@
// port-level checks of the first-fit block allocator, bound to the top level
// depends on ffa_pkg and first_fit_block_allocator_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_block_allocator_defines.svh"

module ffa_checker #(
    parameter int ADDR_BITS = 24
) (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           start,
    input wire                           busy,
    input wire                           o_valid,
    input wire [ffa_pkg::STATUS_W-1:0]   o_status,
    input wire [ADDR_BITS-1:0]           o_address_out
);
    import ffa_pkg::*;

    // status code is one of the defined results
    `FFA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid,
        (o_status == ST_OK || o_status == ST_OOM || o_status == ST_DOUBLE
         || o_status == ST_NOTFOUND || o_status == ST_NULL),
        "result beat carries an undefined status")

    // only a granted allocate carries an address
    `FFA_ASSERT_IMP(a_addr_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_address_out == '0, "failed request returned a nonzero address")

    // an accepted request either starts a scan or answers at once
    `FFA_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, start && !busy,
        busy || o_valid, "accepted request neither scanned nor answered")

    // a scan ends only with its result beat
    `FFA_ASSERT_IMP(a_end_has_result, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n),
        o_valid, "scan ended without a result beat")

endmodule

bind first_fit_block_allocator ffa_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_ffa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_address_out (o_address_out)
);

`default_nettype wire

@@ test/first_fit_block_allocator_tb.sv @@
// self-checking testbench for first_fit_block_allocator: directed and random heap requests
// depends on ffa_pkg and the block; keeps its own copy of the block table for prediction
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

    import ffa_pkg::*;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int ADDR_BITS    = 24;
    localparam logic [ARENA_W-1:0] ARENA_MAX = {ARENA_W{1'b1}};
    localparam logic [ADDR_BITS-1:0] SIZE_MAX = {ADDR_BITS{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_BITS-1:0] address;
    } heap_result_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  i_kind      = KIND_ALLOC;
    logic [ADDR_BITS-1:0]  i_size      = '0;
    logic [ADDR_BITS-1:0]  i_address   = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [ARENA_W-1:0]    i_cfg_data  = '0;
    logic                  busy;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_BITS-1:0]  o_address_out;
    logic                  o_cfg_ready;

    // predicted heap state
    logic [ADDR_BITS-1:0]  heap_base [MAX_BLOCKS];
    logic [ADDR_BITS-1:0]  heap_len  [MAX_BLOCKS];
    bit                    heap_used [MAX_BLOCKS];
    int                    heap_count;
    logic [ARENA_W-1:0]    heap_break;
    logic [ARENA_W-1:0]    heap_arena;

    heap_result_t          expected_results [$];
    int                    mismatch_count  = 0;
    int                    sender_idle_pct = 0;

    first_fit_block_allocator #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_size        (i_size),
        .i_address     (i_address),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_address_out (o_address_out),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // first-fit search, append at the break, free by data address
    function automatic heap_result_t predict_heap_op(input logic kind,
                                                     input logic [ADDR_BITS-1:0] size,
                                                     input logic [ADDR_BITS-1:0] addr);
        heap_result_t r;
        longint       data_addr;
        longint       new_break;
        bit           found;
        int           i;
        r.status  = ST_OK;
        r.address = '0;
        found     = 1'b0;
        if (kind == KIND_ALLOC) begin
            for (i = 0; i < heap_count; i++) begin
                if (!found && !heap_used[i] && heap_len[i] >= size) begin
                    found        = 1'b1;
                    heap_used[i] = 1'b1;
                    r.address    = ADDR_BITS'(heap_base[i] + HEADER_BYTES);
                end
            end
            if (!found) begin
                data_addr = longint'(heap_break) + HEADER_BYTES;
                new_break = data_addr + longint'(size);
                if (heap_count >= MAX_BLOCKS || new_break > longint'(heap_arena) ||
                    data_addr > longint'(SIZE_MAX)) begin
                    r.status = ST_OOM;
                end else begin
                    heap_base[heap_count] = heap_break[ADDR_BITS-1:0];
                    heap_len[heap_count]  = size;
                    heap_used[heap_count] = 1'b1;
                    heap_count++;
                    heap_break = new_break[ARENA_W-1:0];
                    r.address  = data_addr[ADDR_BITS-1:0];
                end
            end
        end else if (addr == '0) begin
            r.status = ST_NULL;
        end else begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < heap_count; i++) begin
                if (!found && longint'(heap_base[i]) + HEADER_BYTES == longint'(addr)) begin
                    found = 1'b1;
                    if (!heap_used[i]) begin
                        r.status = ST_DOUBLE;
                    end else begin
                        heap_used[i] = 1'b0;
                        r.status     = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    // send one request beat, with an optional idle gap before it
    task automatic issue_request(input logic kind, input logic [ADDR_BITS-1:0] size,
                                 input logic [ADDR_BITS-1:0] addr);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 8);
        @(negedge i_clk);
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_kind    <= kind;
        i_size    <= size;
        i_address <= addr;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(predict_heap_op(kind, size, addr));
    endtask

    task automatic alloc_bytes(input logic [ADDR_BITS-1:0] size);
        issue_request(KIND_ALLOC, size, ADDR_BITS'($urandom));
    endtask

    task automatic free_addr(input logic [ADDR_BITS-1:0] addr);
        issue_request(KIND_FREE, ADDR_BITS'($urandom), addr);
    endtask

    // lower start and wait for every outstanding result
    task automatic wait_heap_idle(input int tail);
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // one config beat, only while no request is in flight
    task automatic write_arena(input logic [ARENA_W-1:0] value);
        wait_heap_idle(2);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        heap_arena = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // empty arena, then an arena that holds exactly one header
    task automatic test_arena_edges;
        write_arena('0);
        alloc_bytes('0);
        alloc_bytes(SIZE_MAX);
        free_addr('0);
        free_addr(ADDR_BITS'(HEADER_BYTES));
        write_arena(ARENA_W'(HEADER_BYTES));
        alloc_bytes('0);
        alloc_bytes('0);
        free_addr(ADDR_BITS'(HEADER_BYTES));
        free_addr(ADDR_BITS'(HEADER_BYTES));
        alloc_bytes('0);
        alloc_bytes(ADDR_BITS'(1));
    endtask

    // first free block that is long enough wins, no split
    task automatic test_first_fit;
        write_arena(ARENA_RESET);
        alloc_bytes(ADDR_BITS'(100));
        alloc_bytes(ADDR_BITS'(50));
        alloc_bytes(ADDR_BITS'(200));
        free_addr(ADDR_BITS'(2 * HEADER_BYTES));
        free_addr(ADDR_BITS'(5 * HEADER_BYTES + 150));
        alloc_bytes(ADDR_BITS'(150));
        alloc_bytes(ADDR_BITS'(10));
        free_addr(ADDR_BITS'(2 * HEADER_BYTES + 1));
        free_addr(SIZE_MAX);
        alloc_bytes(SIZE_MAX);
    endtask

    // widest arena with a block that reaches the top address bit
    task automatic test_arena_max;
        logic [ADDR_BITS-1:0] big_addr;
        write_arena(ARENA_MAX);
        alloc_bytes(ADDR_BITS'(24'h800000));
        big_addr = ADDR_BITS'(heap_base[heap_count-1] + HEADER_BYTES);
        free_addr(big_addr);
        free_addr(big_addr);
    endtask

    // random mix: mostly frees of live or freed blocks and small allocations
    task automatic run_random_phase(input int idle_pct, input int items);
        int                   pick;
        int                   slot;
        logic [ADDR_BITS-1:0] value;
        sender_idle_pct = idle_pct;
        repeat (items) begin
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      value = ADDR_BITS'($urandom_range(0, 95));
                else if (pick < 90) value = ADDR_BITS'($urandom_range(0, 4095));
                else                value = ADDR_BITS'($urandom);
                alloc_bytes(value);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    value = '0;
                end else if (pick < 75 && heap_count > 0) begin
                    slot  = $urandom_range(0, heap_count - 1);
                    value = ADDR_BITS'(heap_base[slot] + HEADER_BYTES);
                    // near miss on a real block
                    if ($urandom_range(0, 9) == 0) begin
                        value = ($urandom_range(0, 1) != 0) ? value + ADDR_BITS'(1)
                                                            : value - ADDR_BITS'(1);
                    end
                end else begin
                    value = ADDR_BITS'($urandom);
                end
                free_addr(value);
            end
        end
    endtask

    // append until all table slots are taken; reuse must still work
    task automatic test_table_full;
        int guard;
        write_arena(ARENA_RESET);
        guard = 0;
        while (heap_count < MAX_BLOCKS && guard < MAX_BLOCKS + 4) begin
            alloc_bytes(ADDR_BITS'(24'h1000));
            guard++;
        end
        alloc_bytes(ADDR_BITS'(24'h1000));
        free_addr(ADDR_BITS'(heap_base[0] + HEADER_BYTES));
        alloc_bytes('0);
    endtask

    // break pushed past the data address range; only reuse can succeed
    task automatic test_address_space;
        logic [ADDR_BITS-1:0] big_addr;
        write_arena(ARENA_MAX);
        alloc_bytes(SIZE_MAX);
        big_addr = ADDR_BITS'(heap_base[heap_count-1] + HEADER_BYTES);
        alloc_bytes(SIZE_MAX);
        free_addr(big_addr);
        alloc_bytes(SIZE_MAX);
    endtask

    // result checker: each strobe against the oldest expectation
    always @(posedge i_clk) begin
        heap_result_t exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, status %0d address %h",
                         $time, o_status, o_address_out);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_r.status, o_status);
                    mismatch_count++;
                end
                if (o_address_out !== exp_r.address) begin
                    $display("%0t: address mismatch: expected %h, actual %h",
                             $time, exp_r.address, o_address_out);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        heap_count = 0;
        heap_break = '0;
        heap_arena = ARENA_RESET;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            heap_base[i] = '0;
            heap_len[i]  = '0;
            heap_used[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 31;
        test_arena_edges();
        test_first_fit();
        test_arena_max();

        // arenas just above the break keep the table below full here
        write_arena(heap_break + ARENA_W'($urandom_range(300, 800)));
        run_random_phase(31, 534);
        write_arena(heap_break + ARENA_W'($urandom_range(200, 700)));
        run_random_phase(70, 534);
        // shrunk to at most the break: reuse only
        write_arena(ARENA_W'($urandom_range(0, heap_break)));
        run_random_phase(0, 534);

        // a full table and an exhausted address range exclude each other after one reset
        sender_idle_pct = 0;
        if ($urandom_range(0, 1)) test_table_full();
        else test_address_space();

        wait_heap_idle(MAX_BLOCKS + 8);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ first_fit_block_allocator.f @@
+incdir+sv
sv/ffa_pkg.sv
sv/ffa_table.sv
sv/ffa_ctrl.sv
sv/first_fit_block_allocator.sv
sv/ffa_checker.sv
test/first_fit_block_allocator_tb.sv
